/* rtl/core/tts_pkg.sv */
// Shared types and constants for the time-triggered task scheduler.
// No dependencies.
package tts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CD_W       = 17;

  typedef enum logic [1:0] {
    FN_ADD      = 2'd0,
    FN_START    = 2'd1,
    FN_TICK     = 2'd2,
    FN_DISPATCH = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    F_NONE        = 3'd0,
    F_COPY        = 3'd1,
    F_RUNNING     = 3'd2,
    F_FULL        = 3'd3,
    F_ZERO_PERIOD = 3'd4
  } fault_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [15:0] worst;
    logic [15:0] best;
  } cmd_t;

  typedef struct packed {
    logic        due;
    logic [2:0]  slot;
    logic [15:0] handle;
    logic [15:0] worst;
    logic [15:0] best;
    fault_t      fault;
    logic        more;
    logic        last;
  } res_t;

endpackage

/* rtl/core/time_triggered_task_scheduler.sv */
// Time-triggered task scheduler top level: front queue, executor, result queue.
// Add, start and tick are each executed directly from idle; dispatch with a
// pending tick walks the table one slot per cycle while the result queue is not
// full, then pushes the last held result, or an empty one, marked last.
// Synchronous active-low reset empties both queues, clears pending ticks,
// stops the scheduler and frees all slots. Depends on tts_pkg, tts_front, tts_exec and tts_outq.
module time_triggered_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_task_handle,
  input  logic [15:0] in_first_delay,
  input  logic [15:0] in_period,
  input  logic [15:0] in_worst_time,
  input  logic [15:0] in_best_time,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_task_due,
  output logic [2:0]  out_due_slot,
  output logic [15:0] out_due_handle,
  output logic [15:0] out_due_worst_time,
  output logic [15:0] out_due_best_time,
  output logic [2:0]  out_fault_code,
  output logic        out_more_pending,
  output logic        out_last
);
  import tts_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  res_t res, head;
  logic res_push, res_full;

  tts_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_task_handle, .in_first_delay,
    .in_period, .in_worst_time, .in_best_time,
    .cmd_valid, .cmd, .cmd_take
  );

  tts_exec u_exec (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .res_push, .res, .res_full
  );

  tts_outq u_outq (
    .clk, .rst_n, .push(res_push), .din(res), .full(res_full),
    .pop(out_pop), .empty(out_empty), .dout(head)
  );

  assign out_task_due       = head.due;
  assign out_due_slot       = head.slot;
  assign out_due_handle     = head.handle;
  assign out_due_worst_time = head.worst;
  assign out_due_best_time  = head.best;
  assign out_fault_code     = head.fault;
  assign out_more_pending   = head.more;
  assign out_last           = head.last;

endmodule

/* rtl/core/tts_front.sv */
// Front end: accepts items and decodes the function into a two-entry queue.
// Depends on tts_pkg.
module tts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_task_handle,
  input  logic [15:0]        in_first_delay,
  input  logic [15:0]        in_period,
  input  logic [15:0]        in_worst_time,
  input  logic [15:0]        in_best_time,
  output logic               cmd_valid,
  output tts_pkg::cmd_t      cmd,
  input  logic               cmd_take
);
  import tts_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.func   = func_t'(in_func);
    in_cmd.handle = in_task_handle;
    in_cmd.delay  = in_first_delay;
    in_cmd.period = in_period;
    in_cmd.worst  = in_worst_time;
    in_cmd.best   = in_best_time;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr        = in_push && !in_full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= in_cmd;
  end

endmodule

/* rtl/core/tts_outq.sv */
// Result queue, four entries, between the executor and the out_ ports.
// Depends on tts_pkg.
module tts_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tts_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tts_pkg::res_t dout
);
  import tts_pkg::*;

  res_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = q_r[rp_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= din;
  end

  a_no_overpush: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("result pushed into full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue count out of range");

endmodule

/* rtl/core/tts_exec.sv */
// Back end: task table with inverted copies, tick counter and dispatch walk.
// Depends on tts_pkg.
module tts_exec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  tts_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_push,
  output tts_pkg::res_t res,
  input  logic          res_full
);
  import tts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TASK_SLOTS - 1);

  state_t            st_r, st_nxt;
  logic [31:0]       pend_r, pend_inv_r;
  logic              run_r, run_inv_r;
  logic [15:0]       hdl_r [TASK_SLOTS];
  logic [15:0]       hdl_inv_r [TASK_SLOTS];
  logic [CD_W-1:0]   cd_r [TASK_SLOTS];
  logic [CD_W-1:0]   cd_inv_r [TASK_SLOTS];
  logic [15:0]       per_r [TASK_SLOTS];
  logic [15:0]       per_inv_r [TASK_SLOTS];
  logic [31:0]       tb_r [TASK_SLOTS];
  logic [31:0]       tb_inv_r [TASK_SLOTS];
  logic [SLOT_W-1:0] idx_r;
  res_t              held_r;
  logic              held_v_r;
  logic              more_r;

  logic              free_v;
  logic [SLOT_W-1:0] free_idx;
  fault_t            add_fault, tick_fault;
  logic              run_bad;
  logic              slot_used, slot_ok, slot_due;
  logic [CD_W-1:0]   cd_dec, cd_new;
  logic [31:0]       pend_dec;
  res_t              nil_res, walk_res;
  logic              go;

  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (hdl_r[i] == 16'd0) begin
        free_v   = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign run_bad = (run_r != ~run_inv_r);
  assign pend_dec = pend_r - 32'd1;

  always_comb begin
    if (run_bad)                add_fault = F_COPY;
    else if (run_r)             add_fault = F_RUNNING;
    else if (!free_v)           add_fault = F_FULL;
    else if (cmd.period == '0)  add_fault = F_ZERO_PERIOD;
    else                        add_fault = F_NONE;
    tick_fault = (run_bad || pend_r != ~pend_inv_r) ? F_COPY : F_NONE;
  end

  assign slot_used = (hdl_r[idx_r] != 16'd0);
  assign slot_ok   = (hdl_r[idx_r] == ~hdl_inv_r[idx_r]) &&
                     (cd_r[idx_r] == ~cd_inv_r[idx_r]) &&
                     (per_r[idx_r] == ~per_inv_r[idx_r]) &&
                     (tb_r[idx_r] == ~tb_inv_r[idx_r]);
  assign cd_dec    = cd_r[idx_r] - CD_W'(1);
  assign slot_due  = (cd_dec == '0);
  assign cd_new    = slot_due ? CD_W'(per_r[idx_r]) : cd_dec;

  always_comb begin
    walk_res        = '0;
    walk_res.slot   = 3'(idx_r);
    walk_res.more   = more_r;
    if (!slot_ok) begin
      walk_res.fault = F_COPY;
    end else begin
      walk_res.due    = 1'b1;
      walk_res.handle = hdl_r[idx_r];
      walk_res.worst  = tb_r[idx_r][31:16];
      walk_res.best   = tb_r[idx_r][15:0];
    end
  end

  assign go = !res_full;

  always_comb begin
    st_nxt   = st_r;
    cmd_take = 1'b0;
    res_push = 1'b0;
    nil_res  = '0;
    nil_res.last = 1'b1;
    nil_res.more = (pend_r != 32'd0);
    res      = nil_res;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid && go) begin
          cmd_take = 1'b1;
          res_push = 1'b1;
          case (cmd.func)
            FN_ADD:  res.fault = add_fault;
            FN_TICK: begin
              res.fault = tick_fault;
              if (tick_fault == F_NONE) res.more = 1'b1;
            end
            FN_DISPATCH: begin
              if (pend_r != 32'd0) begin
                res_push = 1'b0;
                st_nxt   = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (go) begin
          if (slot_used && (!slot_ok || slot_due) && held_v_r) begin
            res_push = 1'b1;
            res      = held_r;
          end
          if (idx_r == LAST_IDX) st_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (go) begin
          res_push = 1'b1;
          if (held_v_r) begin
            res      = held_r;
            res.last = 1'b1;
          end else begin
            res.more = more_r;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      pend_r     <= '0;
      pend_inv_r <= '1;
      run_r      <= 1'b0;
      run_inv_r  <= 1'b1;
      idx_r      <= '0;
      held_v_r   <= 1'b0;
      more_r     <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        hdl_r[i]     <= '0;
        hdl_inv_r[i] <= '1;
      end
    end else begin
      st_r <= st_nxt;
      if (cmd_take) begin
        case (cmd.func)
          FN_ADD: begin
            if (add_fault == F_NONE) begin
              hdl_r[free_idx]     <= cmd.handle;
              hdl_inv_r[free_idx] <= ~cmd.handle;
            end
          end
          FN_START: begin
            run_r     <= 1'b1;
            run_inv_r <= 1'b0;
          end
          FN_TICK: begin
            if (tick_fault == F_NONE && pend_r != '1) begin
              pend_r     <= pend_r + 32'd1;
              pend_inv_r <= ~(pend_r + 32'd1);
            end
          end
          FN_DISPATCH: begin
            if (pend_r != 32'd0) begin
              pend_r     <= pend_dec;
              pend_inv_r <= ~pend_dec;
              more_r     <= (pend_dec != 32'd0);
              idx_r      <= '0;
              held_v_r   <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (st_r == ST_WALK && go) begin
        if (slot_used && (!slot_ok || slot_due)) held_v_r <= 1'b1;
        if (idx_r != LAST_IDX) idx_r <= idx_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.func == FN_ADD && add_fault == F_NONE) begin
      cd_r[free_idx]      <= CD_W'(cmd.delay) + CD_W'(1);
      cd_inv_r[free_idx]  <= ~(CD_W'(cmd.delay) + CD_W'(1));
      per_r[free_idx]     <= cmd.period;
      per_inv_r[free_idx] <= ~cmd.period;
      tb_r[free_idx]      <= {cmd.worst, cmd.best};
      tb_inv_r[free_idx]  <= ~{cmd.worst, cmd.best};
    end
    if (st_r == ST_WALK && go && slot_used) begin
      if (slot_ok) begin
        cd_r[idx_r]     <= cd_new;
        cd_inv_r[idx_r] <= ~cd_new;
      end
      if (!slot_ok || slot_due) held_r <= walk_res;
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> st_r == ST_IDLE) else $error("command taken mid-walk");
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && st_nxt == ST_WALK) |=> idx_r == '0 && !held_v_r)
    else $error("walk did not start at slot zero");
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH && res_push) |-> res.last) else $error("flush without last");

endmodule

/* test/time_triggered_task_scheduler_tb.sv */
// Testbench for the time-triggered task scheduler: a directed table of items then random
// add/start/tick/dispatch traffic, with results checked against an in-bench table predictor.
// Depends on tts_pkg and time_triggered_task_scheduler.
`timescale 1ns / 100ps

module time_triggered_task_scheduler_tb;
  import tts_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [15:0] worst;
    logic [15:0] best;
  } sched_item_t;

  typedef struct {
    sched_item_t item;
    bit          typed;
    res_t        want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_func;
  logic [15:0] in_task_handle, in_first_delay, in_period, in_worst_time, in_best_time;
  logic        out_empty;
  logic        out_pop;
  logic        out_task_due;
  logic [2:0]  out_due_slot;
  logic [15:0] out_due_handle, out_due_worst_time, out_due_best_time;
  logic [2:0]  out_fault_code;
  logic        out_more_pending;
  logic        out_last;

  time_triggered_task_scheduler DUT (.*);

  // predictor state
  logic [31:0] ticks_owed;
  logic        sched_running;
  logic [15:0] tab_handle [TASK_SLOTS];
  logic [16:0] tab_count  [TASK_SLOTS];
  logic [15:0] tab_period [TASK_SLOTS];
  logic [15:0] tab_worst  [TASK_SLOTS];
  logic [15:0] tab_best   [TASK_SLOTS];

  res_t due_results [$];
  int   errors;
  bit   rx_quiet;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("time_triggered_task_scheduler: mismatch");
    $finish;
  end

  function automatic res_t blank_result();
    res_t r;
    r = '0;
    r.fault = F_NONE;
    return r;
  endfunction

  function automatic int table_used();
    int n;
    n = 0;
    for (int i = 0; i < TASK_SLOTS; i++) if (tab_handle[i] != 0) n++;
    return n;
  endfunction

  task automatic predict_item(input sched_item_t it);
    res_t r;
    res_t batch [$];
    int   free_slot;
    logic [16:0] cd;
    r = blank_result();
    free_slot = TASK_SLOTS;
    case (func_t'(it.func))
      FN_ADD: begin
        for (int i = TASK_SLOTS - 1; i >= 0; i--) if (tab_handle[i] == 0) free_slot = i;
        if (sched_running) r.fault = F_RUNNING;
        else if (free_slot == TASK_SLOTS) r.fault = F_FULL;
        else if (it.period == 0) r.fault = F_ZERO_PERIOD;
        else begin
          tab_handle[free_slot] = it.handle;
          tab_count[free_slot]  = {1'b0, it.delay} + 17'd1;
          tab_period[free_slot] = it.period;
          tab_worst[free_slot]  = it.worst;
          tab_best[free_slot]   = it.best;
        end
        r.more = ticks_owed != 0;
        batch.push_back(r);
      end
      FN_START: begin
        sched_running = 1'b1;
        r.more = ticks_owed != 0;
        batch.push_back(r);
      end
      FN_TICK: begin
        if (ticks_owed != '1) ticks_owed++;
        r.more = 1'b1;
        batch.push_back(r);
      end
      default: begin
        if (ticks_owed != 0) begin
          ticks_owed--;
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (tab_handle[i] == 0) continue;
            cd = tab_count[i] - 17'd1;
            if (cd == 0) begin
              r = blank_result();
              r.due    = 1'b1;
              r.slot   = i[2:0];
              r.handle = tab_handle[i];
              r.worst  = tab_worst[i];
              r.best   = tab_best[i];
              batch.push_back(r);
              cd = {1'b0, tab_period[i]};
            end
            tab_count[i] = cd;
          end
        end
        if (batch.size() == 0) batch.push_back(blank_result());
        foreach (batch[k]) batch[k].more = ticks_owed != 0;
      end
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) due_results.push_back(batch[k]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // result side
  initial begin
    res_t w;
    out_pop = 1'b0;
    rx_quiet = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_due_handle), 32'd0);
        end else begin
          w = due_results.pop_front();
          if (out_task_due !== w.due)
            report_mismatch("task_due", 32'(out_task_due), 32'(w.due));
          if (out_due_slot !== w.slot)
            report_mismatch("due_slot", 32'(out_due_slot), 32'(w.slot));
          if (out_due_handle !== w.handle)
            report_mismatch("due_handle", 32'(out_due_handle), 32'(w.handle));
          if (out_due_worst_time !== w.worst)
            report_mismatch("due_worst_time", 32'(out_due_worst_time), 32'(w.worst));
          if (out_due_best_time !== w.best)
            report_mismatch("due_best_time", 32'(out_due_best_time), 32'(w.best));
          if (out_fault_code !== w.fault)
            report_mismatch("fault_code", 32'(out_fault_code), 32'(w.fault));
          if (out_more_pending !== w.more)
            report_mismatch("more_pending", 32'(out_more_pending), 32'(w.more));
          if (out_last !== w.last)
            report_mismatch("last", 32'(out_last), 32'(w.last));
        end
      end
      if (rx_quiet) out_pop <= 1'b1;
      else if ($urandom_range(0, 19) == 0) out_pop <= 1'b0;
      else if (!out_pop && $urandom_range(0, 3) != 0) out_pop <= 1'b1;
      else if ($urandom_range(0, 199) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input sched_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_func        <= it.func;
    in_task_handle <= it.handle;
    in_first_delay <= it.delay;
    in_period      <= it.period;
    in_worst_time  <= it.worst;
    in_best_time   <= it.best;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_item(it);
  endtask

  function automatic sched_item_t make_item(logic [1:0] f, logic [15:0] h, logic [15:0] d,
                                            logic [15:0] p, logic [15:0] w, logic [15:0] b);
    sched_item_t it;
    it.func = f; it.handle = h; it.delay = d; it.period = p; it.worst = w; it.best = b;
    return it;
  endfunction

  function automatic sched_item_t rand_item(bit stopped);
    logic [1:0] f;
    logic [15:0] h;
    int r;
    r = $urandom_range(0, 99);
    if (stopped) f = (r < 60) ? FN_ADD : (r < 75) ? FN_TICK : (r < 90) ? FN_DISPATCH : FN_START;
    else f = (r < 45) ? FN_TICK : (r < 90) ? FN_DISPATCH : (r < 95) ? FN_ADD : FN_START;
    h = 16'($urandom);
    if ($urandom_range(0, 15) == 0) h = 0;
    return make_item(f, h, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                     ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 1)) :
                     ($urandom_range(0, 14) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5)),
                     16'($urandom), 16'($urandom));
  endfunction

  task automatic soft_reset_predictor();
    ticks_owed = 0;
    sched_running = 0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tab_handle[i] = 0; tab_count[i] = 0; tab_period[i] = 0; tab_worst[i] = 0; tab_best[i] = 0;
    end
  endtask

  // sender
  initial begin
    row_t        rows [$];
    row_t        rw;
    res_t        exp_r;
    sched_item_t it;
    int          sent;
    int          limit;
    errors = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_func = FN_TICK;
    in_task_handle = 0; in_first_delay = 0; in_period = 0; in_worst_time = 0; in_best_time = 0;
    soft_reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    exp_r = blank_result();
    exp_r.last = 1'b1;
    rw.typed = 1;
    // dispatch with nothing owed
    rw.item = make_item(FN_DISPATCH, 0, 0, 0, 0, 0); rw.want = exp_r; rows.push_back(rw);
    // zero period rejected
    rw.item = make_item(FN_ADD, 16'hFFFF, 0, 0, 0, 0);
    rw.want = exp_r; rw.want.fault = F_ZERO_PERIOD; rows.push_back(rw);
    rw.typed = 0;
    rows.push_back('{make_item(FN_ADD, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h0000, 16'h0002, 16'h0002, 16'h1234, 16'h5678), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'hA5A5, 16'hFFFF, 16'h0003, 16'hAAAA, 16'h5555), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h5A5A, 16'h0000, 16'h0002, 16'h5555, 16'hAAAA), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h0002, 16'h0003, 16'h0004, 16'h0001, 16'h0002), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h0003, 16'h0001, 16'h0001, 16'h0003, 16'h0004), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h7777, 16'h0000, 16'h0001, 0, 0), 0, exp_r});
    // table full
    rows.push_back('{make_item(FN_ADD, 16'h6666, 16'h0000, 16'h0001, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_TICK, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_TICK, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_DISPATCH, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_START, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_START, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_ADD, 16'h0009, 0, 16'h0001, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_DISPATCH, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_TICK, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_DISPATCH, 0, 0, 0, 0, 0), 0, exp_r});
    rows.push_back('{make_item(FN_DISPATCH, 0, 0, 0, 0, 0), 0, exp_r});

    foreach (rows[k]) begin
      if (rows[k].typed) begin
        send_item(rows[k].item);
        void'(due_results.pop_back());
        due_results.push_back(rows[k].want);
      end else begin
        send_item(rows[k].item);
      end
    end

    // random part: the scheduler only stops at reset, so run loads under a fresh bench state
    // is not possible; keep it running with ticks and dispatches, plus rejected adds
    sent = 0;
    while (sent < 210) begin
      it = rand_item(1'b0);
      if (it.func == FN_DISPATCH && ticks_owed == 0 && $urandom_range(0, 3) != 0) it.func = FN_TICK;
      send_item(it);
      sent++;
      if (sent == 100) begin
        in_push <= 1'b0;
        wait (due_results.size() == 0);
        @(posedge clk);
      end
    end
    in_push <= 1'b0;
    rx_quiet = 1'b1;
    limit = 0;
    while (due_results.size() != 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && due_results.size() == 0 && table_used() >= 0)
      $display("time_triggered_task_scheduler: match");
    else
      $display("time_triggered_task_scheduler: mismatch");
    $finish;
  end

endmodule

/* time_triggered_task_scheduler.f */
rtl/core/tts_pkg.sv
rtl/core/tts_front.sv
rtl/core/tts_outq.sv
rtl/core/tts_exec.sv
rtl/core/time_triggered_task_scheduler.sv
test/time_triggered_task_scheduler_tb.sv
